/* hdl/tlv_datagram_checker_macros.svh */
// Assertion macros shared by the TLV datagram checker RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef TLV_DATAGRAM_CHECKER_MACROS_SVH
`define TLV_DATAGRAM_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of clk.
`define TLV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TLV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TLV_ASSERT(lbl, prop, msg)
`define TLV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/tlvdc_pkg.sv */
package tlvdc_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CK_LEN,
		PH_CK_FIRST,
		PH_VALUE,
		PH_D_TYPE,
		PH_D_LEN
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_HEADER   = 3'd1,
		ST_TLV_LEN  = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_END_TYPE = 2'd0,
		REG_CK_TYPE  = 2'd1,
		REG_CK_LEN   = 2'd2,
		REG_MAX_LEN  = 2'd3
	} reg_index_t;

	localparam logic [7:0] END_TYPE_RST = 8'd0;
	localparam logic [7:0] CK_TYPE_RST  = 8'd1;
	localparam logic [3:0] CK_LEN_RST   = 4'd1;
	localparam logic [7:0] MAX_LEN_RST  = 8'd64;

	// Fixed part of a frame that is not data TLV payload
	localparam logic [7:0] TLV_OVERHEAD = 8'd5;

	typedef struct packed {
		logic [7:0] end_type;
		logic [7:0] ck_type;
		logic [3:0] ck_len;
		logic [7:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		status_t    status;
		logic [7:0] total_length;
		logic [7:0] computed_checksum;
	} result_t;

endpackage

/* hdl/tlv_datagram_checker.sv */
// TLV datagram checker.
// Input stream (s_*): one datagram byte per transaction in s_tdata, with s_tuser
// high on the first byte of a frame. Output stream (m_*): one status transaction
// per frame, at the end TLV or at the first error; bytes after that are dropped
// until the next frame start, and a frame start mid-frame drops the open frame
// without a result.
// Configuration: wr_en/wr_index/wr_data write end type, checksum type, checksum
// length and maximum datagram length; write them only while no frame is open.
// Datapath: a byte is captured in an input register, parsed from there and its
// result lands in the output register that drives m_tvalid. One byte per cycle is
// sustained while no pending result stalls the output; the limit is the single
// parser state update per cycle.
// Reset: arst_n clears the parser to idle, empties both registers and loads the
// register defaults.
// Stall: while m_tready is low and a result is pending, the input register holds
// its byte and s_tready falls once it is full; parsing resumes with the transfer.
module tlv_datagram_checker
	import tlvdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] status, [10:3] total_length,
	                               // [18:11] computed_checksum, [23:19] zero
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    res;
	logic       out_free;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{end_type: END_TYPE_RST, ck_type: CK_TYPE_RST,
			           ck_len: CK_LEN_RST, max_len: MAX_LEN_RST};
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_END_TYPE: cfg_q.end_type <= wr_data;
				REG_CK_TYPE:  cfg_q.ck_type  <= wr_data;
				REG_CK_LEN:   cfg_q.ck_len   <= wr_data[3:0];
				REG_MAX_LEN:  cfg_q.max_len  <= wr_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	tlvdc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load only on a real result so a pending one is never overwritten
	always_ff @(posedge clk) begin
		if (advance && res.valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.computed_checksum, out_q.total_length, out_q.status};

	`TLV_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(start_s1), "input register lost a byte")
	`TLV_ASSERT_NEXT(a_out_load, !out_valid_q && !(advance && res.valid), !out_valid_q, "result without a parsed byte")
	`TLV_ASSERT(a_ready_full, s_tready || valid_s1, "input stalled while register empty")

endmodule

/* hdl/tlvdc_parser.sv */
`include "tlv_datagram_checker_macros.svh"

module tlvdc_parser
	import tlvdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  cfg_t       cfg,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] rx_ck_q, rx_ck_d;
	logic [7:0] left_q, left_d;
	logic [8:0] len_q, len_d;
	logic       in_ck_q, in_ck_d;

	logic [7:0] tlv_limit;
	logic       type_bad;
	logic       ck_len_bad;
	logic       len_bad;
	logic       too_long;
	logic       is_end;
	logic       last_value;
	logic [9:0] len_sum;

	assign tlv_limit  = (cfg.max_len >= TLV_OVERHEAD) ? (cfg.max_len - TLV_OVERHEAD) : 8'd0;
	assign type_bad   = (data_byte != cfg.ck_type);
	assign ck_len_bad = (data_byte != {4'd0, cfg.ck_len});
	assign len_bad    = (data_byte == 8'd0) || (data_byte > tlv_limit);
	assign len_sum    = {1'b0, len_q} + 10'd1 + {2'd0, data_byte};
	assign too_long   = (len_sum > {2'd0, cfg.max_len});
	assign is_end     = (data_byte == cfg.end_type);
	assign last_value = (left_q == 8'd1);

	always_comb begin : next_state
		phase_d = phase_q;
		if (frame_start) begin
			phase_d = type_bad ? PH_IDLE : PH_CK_LEN;
		end else begin
			case (phase_q)
				PH_CK_LEN: begin
					phase_d = (ck_len_bad || len_bad) ? PH_IDLE : PH_CK_FIRST;
				end
				PH_CK_FIRST: begin
					phase_d = last_value ? PH_D_TYPE : PH_VALUE;
				end
				PH_VALUE: begin
					if (last_value)
						phase_d = PH_D_TYPE;
				end
				PH_D_TYPE: begin
					phase_d = is_end ? PH_IDLE : PH_D_LEN;
				end
				PH_D_LEN: begin
					phase_d = (len_bad || too_long) ? PH_IDLE : PH_VALUE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin : outputs
		xor_d   = xor_q;
		rx_ck_d = rx_ck_q;
		left_d  = left_q;
		len_d   = len_q;
		in_ck_d = in_ck_q;
		res     = '{valid: 1'b0, status: ST_OK, total_length: 8'd0, computed_checksum: 8'd0};
		if (frame_start) begin
			xor_d   = 8'd0;
			rx_ck_d = 8'd0;
			left_d  = 8'd0;
			in_ck_d = 1'b1;
			if (type_bad) begin
				len_d      = 9'd0;
				res.valid  = 1'b1;
				res.status = ST_HEADER;
			end else begin
				len_d = 9'd1;
			end
		end else begin
			case (phase_q)
				PH_CK_LEN: begin
					if (ck_len_bad || len_bad) begin
						res.valid        = 1'b1;
						res.status       = ck_len_bad ? ST_HEADER : ST_TLV_LEN;
						res.total_length = len_q[7:0];
					end else begin
						len_d  = len_q + 9'd1;
						left_d = data_byte;
					end
				end
				PH_CK_FIRST: begin
					rx_ck_d = data_byte;
					len_d   = len_q + 9'd1;
					left_d  = left_q - 8'd1;
					if (last_value)
						in_ck_d = 1'b0;
				end
				PH_VALUE: begin
					// skip the rest of the checksum value, fold data values
					if (!in_ck_q)
						xor_d = xor_q ^ data_byte;
					len_d  = len_q + 9'd1;
					left_d = left_q - 8'd1;
					if (last_value)
						in_ck_d = 1'b0;
				end
				PH_D_TYPE: begin
					if (is_end) begin
						res.valid             = 1'b1;
						res.status            = (xor_q == rx_ck_q) ? ST_OK : ST_MISMATCH;
						res.total_length      = len_q[7:0] + 8'd1;
						res.computed_checksum = xor_q;
					end else begin
						xor_d = xor_q ^ data_byte;
						len_d = len_q + 9'd1;
					end
				end
				PH_D_LEN: begin
					if (len_bad || too_long) begin
						res.valid             = 1'b1;
						res.status            = len_bad ? ST_TLV_LEN : ST_TOO_LONG;
						res.total_length      = len_q[7:0];
						res.computed_checksum = xor_q;
					end else begin
						xor_d   = xor_q ^ data_byte;
						len_d   = len_q + 9'd1;
						left_d  = data_byte;
						in_ck_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			xor_q   <= 8'd0;
			rx_ck_q <= 8'd0;
			left_q  <= 8'd0;
			len_q   <= 9'd0;
			in_ck_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			rx_ck_q <= rx_ck_d;
			left_q  <= left_d;
			len_q   <= len_d;
			in_ck_q <= in_ck_d;
		end
	end

	`TLV_ASSERT_NEXT(a_result_goes_idle, step && res.valid, phase_q == PH_IDLE, "parser not idle after result")
	`TLV_ASSERT(a_value_count_live, (phase_q != PH_VALUE) || (left_q != 8'd0), "value phase with no bytes left")
	`TLV_ASSERT(a_length_bounded, len_q <= 9'd256, "running length out of range")

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb
	import tlvdc_pkg::*;
;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_BYTES  = 70;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // [2:0] status, [10:3] total_length,
	                        // [18:11] computed_checksum, [23:19] zero
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [7:0]  wr_data;

	typedef struct packed {
		status_t    status;
		logic [7:0] total_length;
		logic [7:0] computed_checksum;
	} verdict_t;

	class datagram_scoreboard;
		cfg_t       regs;
		phase_t     phase;
		logic [7:0] xor_acc;
		logic [7:0] rx_checksum;
		logic [7:0] bytes_left;
		logic [8:0] length_acc;
		bit         in_ck_tlv;
		verdict_t   expected_verdicts[$];
		int         errors;

		function new();
			regs.end_type = END_TYPE_RST;
			regs.ck_type  = CK_TYPE_RST;
			regs.ck_len   = CK_LEN_RST;
			regs.max_len  = MAX_LEN_RST;
			phase         = PH_IDLE;
			xor_acc       = 8'd0;
			rx_checksum   = 8'd0;
			bytes_left    = 8'd0;
			length_acc    = 9'd0;
			in_ck_tlv     = 1'b0;
			errors        = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [7:0] v);
			case (idx)
				REG_END_TYPE: regs.end_type = v;
				REG_CK_TYPE:  regs.ck_type = v;
				REG_CK_LEN:   regs.ck_len = v[3:0];
				REG_MAX_LEN:  regs.max_len = v;
				default: ;
			endcase
		endfunction

		function void report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch: %s", what);
		endfunction

		// Queue a verdict and fall back to dropping bytes until the next start
		function void emit(status_t st, logic [7:0] len, logic [7:0] x);
			verdict_t v;
			v.status            = st;
			v.total_length      = len;
			v.computed_checksum = x;
			expected_verdicts.push_back(v);
			phase = PH_IDLE;
		endfunction

		function void note_byte(logic [7:0] b, logic start);
			int per_tlv_max;
			per_tlv_max = (regs.max_len >= 8'd5) ? int'(regs.max_len) - 5 : 0;
			if (start) begin
				xor_acc     = 8'd0;
				rx_checksum = 8'd0;
				bytes_left  = 8'd0;
				length_acc  = 9'd0;
				in_ck_tlv   = 1'b1;
				if (b != regs.ck_type) begin
					emit(ST_HEADER, 8'd0, 8'd0);
				end else begin
					length_acc = 9'd1;
					phase      = PH_CK_LEN;
				end
			end else begin
				case (phase)
					PH_CK_LEN: begin
						if (b != {4'd0, regs.ck_len})
							emit(ST_HEADER, length_acc[7:0], 8'd0);
						else if (b == 8'd0 || int'(b) > per_tlv_max)
							emit(ST_TLV_LEN, length_acc[7:0], 8'd0);
						else begin
							length_acc++;
							bytes_left = b;
							phase      = PH_CK_FIRST;
						end
					end
					PH_CK_FIRST: begin
						rx_checksum = b;
						length_acc++;
						bytes_left--;
						if (bytes_left == 8'd0) begin
							in_ck_tlv = 1'b0;
							phase     = PH_D_TYPE;
						end else begin
							phase = PH_VALUE;
						end
					end
					PH_VALUE: begin
						if (!in_ck_tlv)
							xor_acc ^= b;
						length_acc++;
						bytes_left--;
						if (bytes_left == 8'd0) begin
							in_ck_tlv = 1'b0;
							phase     = PH_D_TYPE;
						end
					end
					PH_D_TYPE: begin
						if (b == regs.end_type) begin
							emit((xor_acc == rx_checksum) ? ST_OK : ST_MISMATCH,
								length_acc[7:0] + 8'd1, xor_acc);
						end else begin
							xor_acc ^= b;
							length_acc++;
							phase = PH_D_LEN;
						end
					end
					PH_D_LEN: begin
						// length rule wins over the total rule
						if (b == 8'd0 || int'(b) > per_tlv_max)
							emit(ST_TLV_LEN, length_acc[7:0], xor_acc);
						else if (int'(length_acc) + 1 + int'(b) > int'(regs.max_len))
							emit(ST_TOO_LONG, length_acc[7:0], xor_acc);
						else begin
							xor_acc ^= b;
							length_acc++;
							bytes_left = b;
							in_ck_tlv  = 1'b0;
							phase      = PH_VALUE;
						end
					end
					default: ;
				endcase
			end
		endfunction

		function void check_verdict(logic [23:0] d);
			verdict_t want;
			if (expected_verdicts.size() == 0) begin
				report($sformatf("unexpected result tdata=%h", d));
				return;
			end
			want = expected_verdicts.pop_front();
			if (d[2:0] !== want.status)
				report($sformatf("status exp %0d got %0d", want.status, d[2:0]));
			if (d[10:3] !== want.total_length)
				report($sformatf("total_length exp %0d got %0d",
					want.total_length, d[10:3]));
			if (d[18:11] !== want.computed_checksum)
				report($sformatf("computed_checksum exp %h got %h",
					want.computed_checksum, d[18:11]));
		endfunction
	endclass

	datagram_scoreboard sb;
	cfg_t               cur_cfg;
	bit                 s_burst;
	int                 bytes_sent;
	int                 rdy_left = 0;
	int unsigned        cycles = 0;

	tlv_datagram_checker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: check each transaction, then pick the next ready stretch
	always @(posedge clk) begin
		logic rdy_now;
		if (arst_n === 1'b1) begin
			if (m_tvalid && m_tready)
				sb.check_verdict(m_tdata);
			if (rdy_left > 0) begin
				rdy_left--;
			end else begin
				if ($urandom_range(0, 9) < 6) begin
					rdy_now  = 1'b1;
					rdy_left = $urandom_range(1, 40);
				end else begin
					rdy_now  = 1'b0;
					rdy_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
						: $urandom_range(5, 30);
				end
				m_tready <= rdy_now;
			end
		end
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic start);
		int g;
		g = s_burst ? 0 : idle_span();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b, start);
	endtask

	// Hold off until every verdict is in, then give the pipe time to empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_reg(input reg_index_t idx, input logic [7:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic apply_cfg(input cfg_t c);
		wait_idle();
		load_reg(REG_END_TYPE, c.end_type);
		load_reg(REG_CK_TYPE, c.ck_type);
		load_reg(REG_CK_LEN, {4'd0, c.ck_len});
		load_reg(REG_MAX_LEN, c.max_len);
		wr_en   <= 1'b0;
		cur_cfg = c;
	endtask

	// Build a well-formed datagram for the current registers, maybe break it
	task automatic send_frame(input bit clean);
		logic [7:0] fb[$];
		logic [7:0] body[$];
		logic [7:0] x;
		logic [7:0] t;
		int         per_tlv_max;
		int         room;
		int         lmax;
		int         len;
		int         ntlv;
		int         used;
		int         r;
		int         pos;
		bit         stretch;
		per_tlv_max = (cur_cfg.max_len >= 8'd5) ? int'(cur_cfg.max_len) - 5 : 0;
		x       = 8'd0;
		used    = 2 + int'(cur_cfg.ck_len);
		stretch = !clean && ($urandom_range(0, 9) == 0);
		ntlv    = $urandom_range(0, 4);
		for (int i = 0; i < ntlv; i++) begin
			room = int'(cur_cfg.max_len) - used - 2;
			lmax = (room < per_tlv_max) ? room : per_tlv_max;
			// ignore the remaining room to provoke an overlong datagram
			if (stretch && per_tlv_max > 0)
				lmax = per_tlv_max;
			if (lmax < 1)
				break;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, lmax)
				: $urandom_range(1, (lmax < 6) ? lmax : 6);
			t = ($urandom_range(0, 9) == 0) ? cur_cfg.ck_type : 8'($urandom);
			if (t == cur_cfg.end_type)
				t = t + 8'd1;
			body.push_back(t);
			body.push_back(8'(len));
			x ^= t ^ 8'(len);
			repeat (len) begin
				t = 8'($urandom);
				body.push_back(t);
				x ^= t;
			end
			used += 2 + len;
		end
		fb.push_back(cur_cfg.ck_type);
		fb.push_back({4'd0, cur_cfg.ck_len});
		fb.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : x);
		repeat (int'(cur_cfg.ck_len) - 1) fb.push_back(8'($urandom));
		foreach (body[i]) fb.push_back(body[i]);
		fb.push_back(cur_cfg.end_type);
		if (!clean) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				pos     = $urandom_range(0, fb.size() - 1);
				fb[pos] = 8'($urandom);
			end else if (r < 25) begin
				// truncate; the next start drops the open frame
				pos = $urandom_range(1, fb.size() - 1);
				while (fb.size() > pos) void'(fb.pop_back());
			end
		end
		s_burst = ($urandom_range(0, 3) == 0);
		foreach (fb[i]) push_byte(fb[i], i == 0);
		bytes_sent += fb.size();
	endtask

	initial begin
		cfg_t c;
		int   target;
		sb         = new();
		bytes_sent = 0;
		s_burst    = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'd0;
		s_tuser  <= 1'b0;
		wr_en    <= 1'b0;
		wr_index <= REG_END_TYPE;
		wr_data  <= 8'd0;
		cur_cfg = '{END_TYPE_RST, CK_TYPE_RST, CK_LEN_RST, MAX_LEN_RST};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle byte after reset, then a bad checksum type
		push_byte(8'h55, 1'b0);
		push_byte(8'hFF, 1'b1);
		// shortest good frame
		push_byte(8'h01, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// wrong checksum length
		push_byte(8'h01, 1'b1);
		push_byte(8'h02, 1'b0);
		// data TLV reusing the checksum type, checksum does not match
		push_byte(8'h01, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'hAB, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h00, 1'b0);
		// restart mid-frame, then a zero data length
		push_byte(8'h01, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h01, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h00, 1'b0);
		// length that breaks both the per-TLV and the total rule
		push_byte(8'h01, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'hFF, 1'b0);

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: c = '{8'hFF, 8'h00, 4'd8, 8'd255};
				1: c = '{8'h00, 8'hFF, 4'd1, 8'd8};
				default: begin
					c.end_type = 8'($urandom);
					c.ck_type  = 8'($urandom);
					c.ck_len   = 4'($urandom_range(1, 8));
					c.max_len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, 255))
						: 8'($urandom_range(8, 48));
				end
			endcase
			apply_cfg(c);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				case ($urandom_range(0, 9))
					0: repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
					1: push_byte(8'($urandom), 1'b1);
					default: ;
				endcase
				send_frame(1'b0);
			end
			// close the phase with an intact frame so the parser ends idle
			send_frame(1'b1);
		end

		wait_idle();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tlvdc_pkg.sv
hdl/tlvdc_parser.sv
hdl/tlv_datagram_checker.sv
dv/tb.sv
